### src/cart_pendulum_derivatives_defines.svh
// Shared assertion macros for the cart-pendulum block.
`ifndef CART_PENDULUM_DERIVATIVES_DEFINES_SVH
`define CART_PENDULUM_DERIVATIVES_DEFINES_SVH

// Same-cycle implication.
`define CPD_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpd: same-cycle check failed");

// Next-cycle implication.
`define CPD_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpd: next-cycle check failed");

`endif

### src/cpd_pkg.sv
package cpd_pkg;

  typedef logic signed [31:0] fix_t;
  typedef logic [30:0] coef_t;

  localparam fix_t FIX_MAX = 32'sh7fffffff;
  localparam fix_t FIX_MIN = 32'sh80000000;

  // register map (word index)
  typedef enum logic [2:0] {
    REG_PMASS = 3'd0,
    REG_CMASS = 3'd1,
    REG_ARM   = 3'd2,
    REG_GRAV  = 3'd3,
    REG_CDAMP = 3'd4
  } reg_idx_t;

  localparam logic [30:0] RST_PMASS = 31'd65536;
  localparam logic [30:0] RST_CMASS = 31'd327680;
  localparam logic [30:0] RST_ARM   = 31'd131072;
  localparam fix_t        RST_GRAV  = -32'sd655360;
  localparam logic [30:0] RST_CDAMP = 31'd65536;

  // angle -> 32-bit turn phase: 2^32/(2*pi)
  localparam fix_t        PHASE_K = 32'sd683565276;
  localparam logic [31:0] QUARTER = 32'h40000000;

  // sine polynomial, Q30
  localparam coef_t Q30_ONE  = 31'h40000000;
  localparam coef_t SIN_C11  = 31'd3864;
  localparam coef_t SIN_COEF [5] = '{31'd172272, 31'd5026995, 31'd85569306,
                                     31'd693598668, 31'd1686629713};
  localparam logic [32:0] SIN_HALF = 33'd8192;

  localparam int SIN_LAT    = 8;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = 12;
  localparam int DIV_LAT    = DIV_STAGES + 2;
  localparam int P_LAST     = SIN_LAT + 4;
  localparam int PIPE_LAST  = P_LAST + DIV_LAT;

  typedef struct packed {
    fix_t d_position;
    fix_t d_velocity;
    fix_t d_angle;
    fix_t d_rate;
  } res_t;

  function automatic logic [31:0] mag(input fix_t a);
    return a[31] ? 32'(32'd0 - a) : 32'(a);
  endfunction

  function automatic fix_t signsat(input logic neg, input logic [47:0] q);
    if (!neg) begin
      return (q > 48'h7fffffff) ? FIX_MAX : fix_t'(q[31:0]);
    end
    return (q > 48'h80000000) ? FIX_MIN : fix_t'(32'd0 - q[31:0]);
  endfunction

  function automatic fix_t mulq(input fix_t a, input fix_t b);
    logic [63:0] p;
    p = 64'(mag(a)) * 64'(mag(b));
    return signsat(a[31] ^ b[31], p[63:16]);
  endfunction

  function automatic fix_t sadd(input fix_t a, input fix_t b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? FIX_MIN : FIX_MAX;
    end
    return fix_t'(s[31:0]);
  endfunction

  function automatic fix_t sneg(input fix_t a);
    return (a == FIX_MIN) ? FIX_MAX : fix_t'(32'd0 - a);
  endfunction

endpackage

### src/cpd_sin.sv
// Pipelined sine of a 32-bit turn phase, Q16.16 out. Eight register ranks.
module cpd_sin (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        ph,
  output cpd_pkg::fix_t      sin_q
);

  cpd_pkg::coef_t t_r  [0:6];
  logic [1:0]     q_r  [0:6];
  cpd_pkg::coef_t t2_r [1:5];
  cpd_pkg::coef_t p_r  [2:6];
  logic [31:0]    v;
  logic [18:0]    r;

  assign v = 32'((62'(t_r[6]) * 62'(p_r[6])) >> 30);
  assign r = 19'((33'(v) + cpd_pkg::SIN_HALF) >> 14);

  always_ff @(posedge clk) begin
    if (en) begin
      // mirror odd quadrants
      t_r[0] <= ph[30] ? 31'(cpd_pkg::Q30_ONE - 31'(ph[29:0])) : 31'(ph[29:0]);
      q_r[0] <= ph[31:30];
      for (int k = 1; k <= 6; k++) begin
        t_r[k] <= t_r[k-1];
        q_r[k] <= q_r[k-1];
      end
      t2_r[1] <= 31'((62'(t_r[0]) * 62'(t_r[0])) >> 30);
      for (int k = 2; k <= 5; k++) begin
        t2_r[k] <= t2_r[k-1];
      end
      // Horner, one coefficient per rank
      p_r[2] <= cpd_pkg::SIN_COEF[0]
                - 31'((62'(t2_r[1]) * 62'(cpd_pkg::SIN_C11)) >> 30);
      for (int k = 3; k <= 6; k++) begin
        p_r[k] <= cpd_pkg::SIN_COEF[k-2]
                  - 31'((62'(t2_r[k-1]) * 62'(p_r[k-1])) >> 30);
      end
      sin_q <= q_r[6][1] ? cpd_pkg::fix_t'(32'd0 - 32'(r))
                         : cpd_pkg::fix_t'(32'(r));
    end
  end

endmodule

### src/cpd_div.sv
// Pipelined saturating Q16.16 divide: setup rank, twelve 4-bit ranks, sign rank.
module cpd_div (
  input  logic          clk,
  input  logic          en,
  input  cpd_pkg::fix_t num,
  input  cpd_pkg::fix_t den,
  output cpd_pkg::fix_t quo
);

  typedef struct packed {
    logic [31:0] rem;
    logic [47:0] x;
    logic [47:0] q;
  } div_st_t;

  function automatic div_st_t div_step(input div_st_t s, input logic [31:0] ud);
    div_st_t     o;
    logic [32:0] r;
    o = s;
    for (int i = 0; i < cpd_pkg::DIV_STEPS; i++) begin
      r   = {o.rem, o.x[47]};
      o.x = {o.x[46:0], 1'b0};
      if (r >= {1'b0, ud}) begin
        o.rem = 32'(r - {1'b0, ud});
        o.q   = {o.q[46:0], 1'b1};
      end else begin
        o.rem = r[31:0];
        o.q   = {o.q[46:0], 1'b0};
      end
    end
    return o;
  endfunction

  div_st_t       st     [0:cpd_pkg::DIV_STAGES];
  logic [31:0]   ud_r   [0:cpd_pkg::DIV_STAGES-1];
  logic          neg_r  [0:cpd_pkg::DIV_STAGES];
  logic          dz_r   [0:cpd_pkg::DIV_STAGES];
  cpd_pkg::fix_t zres_r [0:cpd_pkg::DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      st[0]     <= '{rem: 32'd0, x: {cpd_pkg::mag(num), 16'd0}, q: 48'd0};
      ud_r[0]   <= cpd_pkg::mag(den);
      neg_r[0]  <= num[31] ^ den[31];
      dz_r[0]   <= (den == 32'sd0);
      // zero divisor: 0 for 0, else the limit with the numerator's sign
      zres_r[0] <= (num == 32'sd0) ? 32'sd0 :
                   (num[31] ? cpd_pkg::FIX_MIN : cpd_pkg::FIX_MAX);
      for (int k = 1; k <= cpd_pkg::DIV_STAGES; k++) begin
        st[k]     <= div_step(st[k-1], ud_r[k-1]);
        neg_r[k]  <= neg_r[k-1];
        dz_r[k]   <= dz_r[k-1];
        zres_r[k] <= zres_r[k-1];
      end
      for (int k = 1; k < cpd_pkg::DIV_STAGES; k++) begin
        ud_r[k] <= ud_r[k-1];
      end
      quo <= dz_r[cpd_pkg::DIV_STAGES] ? zres_r[cpd_pkg::DIV_STAGES]
             : cpd_pkg::signsat(neg_r[cpd_pkg::DIV_STAGES], st[cpd_pkg::DIV_STAGES].q);
    end
  end

endmodule

### src/cpd_obuf.sv
`include "cart_pendulum_derivatives_defines.svh"

// Output register plus one skid entry.
module cpd_obuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cpd_pkg::res_t din,
  output logic          out_valid,
  input  logic          out_ready,
  output cpd_pkg::res_t dout,
  output logic          skid_full
);

  cpd_pkg::res_t skid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (push) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (out_valid && out_ready) begin
      if (skid_full) begin
        skid_full <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_valid || out_ready) begin
        dout <= din;
      end else begin
        skid <= din;
      end
    end else if (out_valid && out_ready && skid_full) begin
      dout <= skid;
    end
  end

  `CPD_ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_full, out_valid)
  `CPD_ASSERT_NEXT(a_blocked_push_fills_skid, clk, rst, push && out_valid && !out_ready, skid_full)

endmodule

### src/cart_pendulum_derivatives.sv
// Cart-pendulum plant derivatives, signed Q16.16 throughout, all steps saturating.
// One beat in, one beat out; a new beat is taken every cycle while the output side
// keeps up. Pipeline ranks from input accept to the output register: one input rank,
// eight ranks of the sine/cosine polynomial, four ranks of the equation products,
// fourteen ranks of the two parallel dividers. Past the last rank sits an output
// register and one skid entry; the whole pipeline holds only while the skid entry
// is occupied, so in_ready drops in the cycle after a result meets a stalled output.
// Config writes go through the APB-style port (byte address = register index * 4)
// and should be made with no beats in flight; products of the registers are
// re-registered, so after a write allow for that register to update before the next beat.
// cart_position is accepted but does not enter any result.
`include "cart_pendulum_derivatives_defines.svh"

module cart_pendulum_derivatives (
  input  logic                 clk,
  input  logic                 rst,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // input beat
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   cart_position,
  input  logic signed [31:0]   cart_velocity,
  input  logic signed [31:0]   pend_angle,
  input  logic signed [31:0]   pend_rate,
  input  logic signed [31:0]   drive_force,
  input  logic signed [31:0]   dist_position,
  input  logic signed [31:0]   dist_velocity,
  input  logic signed [31:0]   dist_angle,
  input  logic signed [31:0]   dist_rate,
  // output beat
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   d_position,
  output logic signed [31:0]   d_velocity,
  output logic signed [31:0]   d_angle,
  output logic signed [31:0]   d_rate
);

  // terms that ride to the output
  typedef struct packed {
    cpd_pkg::fix_t res0;
    cpd_pkg::fix_t res2;
    cpd_pkg::fix_t d1;
    cpd_pkg::fix_t d3;
  } tail_t;

  // terms needed once sine/cosine are ready
  typedef struct packed {
    cpd_pkg::fix_t mlw;   // w*w at rank 0, m*L*w*w from rank 1
    cpd_pkg::fix_t dv;
    cpd_pkg::fix_t u;
  } front_t;

  // config registers
  logic [30:0]   pmass, cmass, alen, cdamp;
  cpd_pkg::fix_t grav;
  // register products, refreshed every cycle
  cpd_pkg::fix_t mlen, mg, mmg;

  logic                      en;
  logic                      skid_full;
  logic [cpd_pkg::PIPE_LAST:0] vld;
  logic signed [63:0]        pp;
  logic [31:0]               ph_s, ph_c;
  cpd_pkg::fix_t             s8, c8;
  cpd_pkg::fix_t             s8_hold;
  tail_t                     tail_r [0:cpd_pkg::PIPE_LAST];
  front_t                    fr_r   [0:cpd_pkg::SIN_LAT];

  cpd_pkg::fix_t p1_ss, p1_mgc, p1_tw, p1_mmgs, p1_dv, p1_u, p1_c;
  cpd_pkg::fix_t p2_mss, p2_mgcs, p2_tu, p2_c, p2_mmgs;
  cpd_pkg::fix_t p3_den, p3_n1, p3_ctu, p3_mmgs;
  cpd_pkg::fix_t p4_ld, p4_n3, p4_n1, p4_den;
  cpd_pkg::fix_t q1, q3;
  cpd_pkg::res_t fin, res_o;

  // ---------------- config port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pmass <= cpd_pkg::RST_PMASS;
      cmass <= cpd_pkg::RST_CMASS;
      alen  <= cpd_pkg::RST_ARM;
      grav  <= cpd_pkg::RST_GRAV;
      cdamp <= cpd_pkg::RST_CDAMP;
    end else if (psel && penable && pwrite) begin
      case (cpd_pkg::reg_idx_t'(paddr[4:2]))
        cpd_pkg::REG_PMASS: pmass <= pwdata[30:0];
        cpd_pkg::REG_CMASS: cmass <= pwdata[30:0];
        cpd_pkg::REG_ARM:   alen  <= pwdata[30:0];
        cpd_pkg::REG_GRAV:  grav  <= cpd_pkg::fix_t'(pwdata);
        cpd_pkg::REG_CDAMP: cdamp <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cpd_pkg::reg_idx_t'(paddr[4:2]))
      cpd_pkg::REG_PMASS: prdata = {1'b0, pmass};
      cpd_pkg::REG_CMASS: prdata = {1'b0, cmass};
      cpd_pkg::REG_ARM:   prdata = {1'b0, alen};
      cpd_pkg::REG_GRAV:  prdata = 32'(grav);
      cpd_pkg::REG_CDAMP: prdata = {1'b0, cdamp};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    mlen <= cpd_pkg::mulq({1'b0, pmass}, {1'b0, alen});
    mg   <= cpd_pkg::mulq({1'b0, pmass}, grav);
    mmg  <= cpd_pkg::mulq(cpd_pkg::sadd({1'b0, pmass}, {1'b0, cmass}), grav);
  end

  // ---------------- flow control ----------------
  // whole pipeline moves together; only the skid entry stops it
  assign en       = !skid_full;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[cpd_pkg::PIPE_LAST-1:0], in_valid};
    end
  end

  // ---------------- rank 0: phase and state-only terms ----------------
  assign pp = pend_angle * cpd_pkg::PHASE_K;

  always_ff @(posedge clk) begin
    if (en) begin
      ph_s      <= pp[47:16];
      ph_c      <= pp[47:16] + cpd_pkg::QUARTER;   // cos = sin a quarter turn on
      fr_r[0]   <= '{mlw: cpd_pkg::mulq(pend_rate, pend_rate),
                     dv:  cpd_pkg::mulq({1'b0, cdamp}, cart_velocity),
                     u:   drive_force};
      tail_r[0] <= '{res0: cpd_pkg::sadd(cart_velocity, dist_position),
                     res2: cpd_pkg::sadd(pend_rate, dist_angle),
                     d1:   dist_velocity,
                     d3:   dist_rate};
      fr_r[1]   <= '{mlw: cpd_pkg::mulq(mlen, fr_r[0].mlw),
                     dv:  fr_r[0].dv,
                     u:   fr_r[0].u};
      for (int k = 2; k <= cpd_pkg::SIN_LAT; k++) begin
        fr_r[k] <= fr_r[k-1];
      end
      for (int k = 1; k <= cpd_pkg::PIPE_LAST; k++) begin
        tail_r[k] <= tail_r[k-1];
      end
    end
  end

  // ---------------- ranks 1..8: sine and cosine ----------------
  cpd_sin u_sin (.clk(clk), .en(en), .ph(ph_s), .sin_q(s8));
  cpd_sin u_cos (.clk(clk), .en(en), .ph(ph_c), .sin_q(c8));

  // ---------------- ranks 9..12: equation products ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      // rank 9
      p1_ss   <= cpd_pkg::mulq(s8, s8);
      p1_mgc  <= cpd_pkg::mulq(mg, c8);
      p1_tw   <= cpd_pkg::mulq(fr_r[cpd_pkg::SIN_LAT].mlw, s8);
      p1_mmgs <= cpd_pkg::mulq(mmg, s8);
      p1_dv   <= fr_r[cpd_pkg::SIN_LAT].dv;
      p1_u    <= fr_r[cpd_pkg::SIN_LAT].u;
      p1_c    <= c8;
      // rank 10: T - d*v + u
      p2_mss  <= cpd_pkg::mulq({1'b0, pmass}, p1_ss);
      p2_mgcs <= cpd_pkg::mulq(p1_mgc, s8_hold);
      p2_tu   <= cpd_pkg::sadd(cpd_pkg::sadd(p1_tw, cpd_pkg::sneg(p1_dv)), p1_u);
      p2_c    <= p1_c;
      p2_mmgs <= p1_mmgs;
      // rank 11: denominator, first numerator
      p3_den  <= cpd_pkg::sadd({1'b0, cmass}, p2_mss);
      p3_n1   <= cpd_pkg::sadd(cpd_pkg::sneg(p2_mgcs), p2_tu);
      p3_ctu  <= cpd_pkg::mulq(p2_c, p2_tu);
      p3_mmgs <= p2_mmgs;
      // rank 12: L*D, second numerator
      p4_ld   <= cpd_pkg::mulq({1'b0, alen}, p3_den);
      p4_n3   <= cpd_pkg::sadd(p3_mmgs, cpd_pkg::sneg(p3_ctu));
      p4_n1   <= p3_n1;
      p4_den  <= p3_den;
    end
  end

  // sine held one rank for the second product with m*g*C
  always_ff @(posedge clk) begin
    if (en) begin
      s8_hold <= s8;
    end
  end

  // ---------------- ranks 13..26: dividers ----------------
  cpd_div u_div_v (.clk(clk), .en(en), .num(p4_n1), .den(p4_den), .quo(q1));
  cpd_div u_div_r (.clk(clk), .en(en), .num(p4_n3), .den(p4_ld),  .quo(q3));

  always_comb begin
    fin.d_position = tail_r[cpd_pkg::PIPE_LAST].res0;
    fin.d_velocity = cpd_pkg::sadd(q1, tail_r[cpd_pkg::PIPE_LAST].d1);
    fin.d_angle    = tail_r[cpd_pkg::PIPE_LAST].res2;
    fin.d_rate     = cpd_pkg::sadd(q3, tail_r[cpd_pkg::PIPE_LAST].d3);
  end

  // ---------------- output register and skid ----------------
  cpd_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (en && vld[cpd_pkg::PIPE_LAST]),
    .din       (fin),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (res_o),
    .skid_full (skid_full)
  );

  assign d_position = res_o.d_position;
  assign d_velocity = res_o.d_velocity;
  assign d_angle    = res_o.d_angle;
  assign d_rate     = res_o.d_rate;

  `CPD_ASSERT_NEXT(a_stall_freezes_valids, clk, rst, !en, $stable(vld))
  `CPD_ASSERT_NEXT(a_exit_reaches_output, clk, rst, en && vld[cpd_pkg::PIPE_LAST], out_valid)

endmodule
